FILE: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared sizes, command and status codes and the result record of the
// positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned LEN_W  = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STAT_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_READ       = 3'd2,
    CMD_FIND_FIRST = 3'd3,
    CMD_FIND_ALL   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [VAL_W-1:0]  read_value;
    logic [IDX_W-1:0]  found_slot;
    logic [LEN_W-1:0]  match_count;
    logic [LEN_W-1:0]  length_now;
    logic              last;
  } res_t;

endpackage

FILE: rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with insert, remove, read, find-first
// and find-all commands, built around one memory port pair and a sequencer.
// ----------------------------------------------------------------------------
// Sequence: error and unused-code commands answer in the cycle after the start
//   beat; a read answers from S_RD_OUT; an insert shifts the tail up, then writes
//   the value in S_INS_FIN; a remove shifts entries down; the finds walk the list.
// Throughput: one command at a time; busy_o stays high while the memory walk
//   (one entry move or one compare per cycle) is running.
// Results are one-cycle strobes on done_o; the receiver cannot stall them.
// Reset clears the length to zero; the entry memory is not cleared.
module positional_list_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [ple_pkg::CMD_W-1:0]       cmd_i,
  input  logic signed [ple_pkg::VAL_W-1:0] item_value_i,
  input  logic [ple_pkg::IDX_W-1:0]       slot_i,
  output logic                            done_o,
  output logic [ple_pkg::STAT_W-1:0]      status_o,
  output logic signed [ple_pkg::VAL_W-1:0] read_value_o,
  output logic [ple_pkg::IDX_W-1:0]       found_slot_o,
  output logic [ple_pkg::LEN_W-1:0]       match_count_o,
  output logic [ple_pkg::LEN_W-1:0]       length_now_o,
  output logic                            last_o
);

  localparam int unsigned IdxW = ple_pkg::IDX_W;
  localparam int unsigned LenW = ple_pkg::LEN_W;
  localparam int unsigned ValW = ple_pkg::VAL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_FIN,
    S_REM,
    S_RD_OUT,
    S_FIND_FIRST,
    S_FIND_ALL
  } state_e;

  // Sequencer state
  state_e            state_q;
  logic [LenW-1:0]   ptr_q;     // walking index, wide enough to hold the length
  logic [IdxW-1:0]   pos_q;     // insert position
  logic [ValW-1:0]   val_q;     // value to insert or search key
  logic [LenW-1:0]   len_q;     // current list length
  logic [LenW-1:0]   cnt_q;     // find-all match count

  // Pipeline marks behind the registered memory read
  logic              wr_pend_q; // rdata_q is to be written back at wr_addr_q
  logic [IdxW-1:0]   wr_addr_q;
  logic              cmp_pend_q; // rdata_q is to be compared, it came from cmp_idx_q
  logic [IdxW-1:0]   cmp_idx_q;

  // Result beat
  logic              done_q;
  ple_pkg::res_t     res_q;

  // Entry memory
  logic [ValW-1:0]   mem_q [ple_pkg::DEPTH];
  logic [ValW-1:0]   rdata_q;
  logic [IdxW-1:0]   mem_raddr;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [ValW-1:0]   mem_wdata;

  logic [LenW-1:0]   ptr_dec;
  logic [LenW-1:0]   ptr_inc;
  logic [LenW-1:0]   slot_ext;
  logic [LenW-1:0]   pos_ext;
  logic              hit;

  function automatic ple_pkg::res_t mk_res(input ple_pkg::status_e st,
                                           input logic [ValW-1:0] rv,
                                           input logic [IdxW-1:0] fs,
                                           input logic [LenW-1:0] mc,
                                           input logic [LenW-1:0] ln,
                                           input logic            lst);
    ple_pkg::res_t r;
    r.status      = st;
    r.read_value  = rv;
    r.found_slot  = fs;
    r.match_count = mc;
    r.length_now  = ln;
    r.last        = lst;
    return r;
  endfunction

  assign ptr_dec  = ptr_q - LenW'(1);
  assign ptr_inc  = ptr_q + LenW'(1);
  assign slot_ext = LenW'(slot_i);
  assign pos_ext  = LenW'(pos_q);

  // The one shared comparator: key against the entry read last cycle.
  assign hit = cmp_pend_q && (rdata_q == val_q);

  // Read address: the slot while idle (feeds a read command), else the walk.
  always_comb begin
    case (state_q)
      S_IDLE:       mem_raddr = slot_i;
      S_INS:        mem_raddr = ptr_dec[IdxW-1:0];
      S_REM:        mem_raddr = ptr_inc[IdxW-1:0];
      S_FIND_FIRST: mem_raddr = ptr_q[IdxW-1:0];
      S_FIND_ALL:   mem_raddr = ptr_q[IdxW-1:0];
      default:      mem_raddr = slot_i;
    endcase
  end

  // Write port: move the entry read last cycle, or drop the new value in.
  always_comb begin
    if (state_q == S_INS_FIN) begin
      mem_we    = 1'b1;
      mem_waddr = pos_q;
      mem_wdata = val_q;
    end else begin
      mem_we    = wr_pend_q;
      mem_waddr = wr_addr_q;
      mem_wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ptr_q      <= '0;
      pos_q      <= '0;
      val_q      <= '0;
      len_q      <= '0;
      cnt_q      <= '0;
      wr_pend_q  <= 1'b0;
      wr_addr_q  <= '0;
      cmp_pend_q <= 1'b0;
      cmp_idx_q  <= '0;
      done_q     <= 1'b0;
      res_q      <= '0;
    end else begin
      done_q     <= 1'b0;
      wr_pend_q  <= 1'b0;
      cmp_pend_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            case (cmd_i)
              ple_pkg::CMD_INSERT: begin
                if (len_q >= LenW'(ple_pkg::DEPTH)) begin
                  done_q <= 1'b1;
                  res_q  <= mk_res(ple_pkg::ST_FULL, '0, '0, '0, len_q, 1'b1);
                end else if (slot_ext > len_q) begin
                  done_q <= 1'b1;
                  res_q  <= mk_res(ple_pkg::ST_BAD_POS, '0, '0, '0, len_q, 1'b1);
                end else begin
                  ptr_q   <= len_q;
                  pos_q   <= slot_i;
                  val_q   <= item_value_i;
                  state_q <= S_INS;
                end
              end
              ple_pkg::CMD_REMOVE, ple_pkg::CMD_READ: begin
                if (len_q == '0) begin
                  done_q <= 1'b1;
                  res_q  <= mk_res(ple_pkg::ST_EMPTY, '0, '0, '0, len_q, 1'b1);
                end else if (slot_ext >= len_q) begin
                  done_q <= 1'b1;
                  res_q  <= mk_res(ple_pkg::ST_BAD_POS, '0, '0, '0, len_q, 1'b1);
                end else begin
                  ptr_q   <= slot_ext;
                  // rdata_q picks up the slot at this edge for a read
                  state_q <= (cmd_i == ple_pkg::CMD_READ) ? S_RD_OUT : S_REM;
                end
              end
              ple_pkg::CMD_FIND_FIRST, ple_pkg::CMD_FIND_ALL: begin
                if (len_q == '0) begin
                  done_q <= 1'b1;
                  res_q  <= mk_res(ple_pkg::ST_EMPTY, '0, '0, '0, len_q, 1'b1);
                end else begin
                  ptr_q   <= '0;
                  cnt_q   <= '0;
                  val_q   <= item_value_i;
                  state_q <= (cmd_i == ple_pkg::CMD_FIND_ALL) ? S_FIND_ALL : S_FIND_FIRST;
                end
              end
              default: begin
                // unused code: no change, plain ok
                done_q <= 1'b1;
                res_q  <= mk_res(ple_pkg::ST_OK, '0, '0, '0, len_q, 1'b1);
              end
            endcase
          end
        end

        // Shift up from the tail: read ptr-1 now, write it at ptr next cycle.
        S_INS: begin
          if (ptr_q > pos_ext) begin
            wr_pend_q <= 1'b1;
            wr_addr_q <= ptr_q[IdxW-1:0];
            ptr_q     <= ptr_dec;
          end else begin
            state_q <= S_INS_FIN;
          end
        end

        S_INS_FIN: begin
          len_q   <= len_q + LenW'(1);
          done_q  <= 1'b1;
          res_q   <= mk_res(ple_pkg::ST_OK, '0, '0, '0, len_q + LenW'(1), 1'b1);
          state_q <= S_IDLE;
        end

        // Shift down toward the slot: read ptr+1 now, write it at ptr next cycle.
        S_REM: begin
          if (ptr_inc < len_q) begin
            wr_pend_q <= 1'b1;
            wr_addr_q <= ptr_q[IdxW-1:0];
            ptr_q     <= ptr_inc;
          end else begin
            // last pending move lands at this same edge
            len_q   <= len_q - LenW'(1);
            done_q  <= 1'b1;
            res_q   <= mk_res(ple_pkg::ST_OK, '0, '0, '0, len_q - LenW'(1), 1'b1);
            state_q <= S_IDLE;
          end
        end

        S_RD_OUT: begin
          done_q  <= 1'b1;
          res_q   <= mk_res(ple_pkg::ST_OK, rdata_q, '0, '0, len_q, 1'b1);
          state_q <= S_IDLE;
        end

        S_FIND_FIRST: begin
          if (hit) begin
            done_q  <= 1'b1;
            res_q   <= mk_res(ple_pkg::ST_OK, '0, cmp_idx_q, '0, len_q, 1'b1);
            state_q <= S_IDLE;
          end else if (ptr_q < len_q) begin
            cmp_pend_q <= 1'b1;
            cmp_idx_q  <= ptr_q[IdxW-1:0];
            ptr_q      <= ptr_inc;
          end else if (!cmp_pend_q) begin
            done_q  <= 1'b1;
            res_q   <= mk_res(ple_pkg::ST_NOT_FOUND, '0, '0, '0, len_q, 1'b1);
            state_q <= S_IDLE;
          end
        end

        S_FIND_ALL: begin
          if (ptr_q < len_q) begin
            cmp_pend_q <= 1'b1;
            cmp_idx_q  <= ptr_q[IdxW-1:0];
            ptr_q      <= ptr_inc;
          end
          if (hit) begin
            // one beat per match, in ascending order
            done_q <= 1'b1;
            res_q  <= mk_res(ple_pkg::ST_OK, '0, cmp_idx_q, '0, len_q, 1'b0);
            cnt_q  <= cnt_q + LenW'(1);
          end else if ((ptr_q >= len_q) && !cmp_pend_q) begin
            // closing beat carries the count
            done_q  <= 1'b1;
            res_q   <= (cnt_q == '0)
                       ? mk_res(ple_pkg::ST_NOT_FOUND, '0, '0, '0, len_q, 1'b1)
                       : mk_res(ple_pkg::ST_OK, '0, '0, cnt_q, len_q, 1'b1);
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = res_q.status;
  assign read_value_o  = res_q.read_value;
  assign found_slot_o  = res_q.found_slot;
  assign match_count_o = res_q.match_count;
  assign length_now_o  = res_q.length_now;
  assign last_o        = res_q.last;

`ifndef NO_ASSERTIONS
  // a beat that is not the final one means the find-all walk is still going
  a_mid_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !res_q.last) |-> busy_o)
    else $error("non-final result while sequencer idle");

  // the length never passes the capacity
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(ple_pkg::DEPTH))
    else $error("list length beyond capacity");

  // an accepted command either starts a walk or answers at once
  a_start_reacts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_q))
    else $error("accepted command produced neither work nor result");

  // no entry move may still be in flight once the sequencer is idle
  a_no_stray_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !wr_pend_q)
    else $error("memory write pending while idle");

  // the length only moves on the cycle a result is produced
  a_len_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != $past(len_q)) |-> done_q)
    else $error("length changed without a result beat");
`endif

endmodule
